// ===== rtl/rgb_pkg.sv =====
// Shared types and constants for the radial glow blender.
`default_nettype none

package rgb_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int RATIO_W   = 16;
    localparam int CHAN_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_GLOW_RADIUS,
        CFG_GLOW_RED,
        CFG_GLOW_GREEN,
        CFG_GLOW_BLUE,
        CFG_GLOW_ALPHA
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              in_glow;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_if.sv =====
// Pixel input and output word channels.
`default_nettype none

interface pix_in_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            dst_red;
    logic [7:0]            dst_green;
    logic [7:0]            dst_blue;
    logic [7:0]            dst_alpha;

    modport source (output valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue, dst_alpha,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue, dst_alpha,
                  output ready);
endinterface

interface pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       inside_glow;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, inside_glow,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, inside_glow,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_dist.sv =====
// Squared distance, inside test and Q.16 scaling of the squared distance.
`default_nettype none

module rgb_dist
    import rgb_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4,
    parameter int D2_W       = 2*COORD_BITS + 18
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [COORD_BITS-1:0]           pixel_x,
    input  wire logic [COORD_BITS-1:0]           pixel_y,
    input  wire side_t                           in_side,
    input  wire logic [COORD_BITS+FRAC_BITS-1:0] center_x,
    input  wire logic [COORD_BITS+FRAC_BITS-1:0] center_y,
    input  wire logic [COORD_BITS+FRAC_BITS-1:0] glow_radius,
    output logic                                 out_valid,
    output logic [D2_W-1:0]                      d2q,
    output side_t                                out_side
);

    localparam int P    = COORD_BITS + FRAC_BITS;
    localparam int XW   = P + 1;
    localparam int SQW  = 2 * XW;
    localparam int SUMW = SQW + 1;

    logic [XW-1:0]   pcx, pcy, ccx, ccy, rr;
    logic [XW-1:0]   dx_next, dy_next;
    logic [SUMW-1:0] d2;
    logic [D2_W-1:0] d2q_next;
    side_t           side3_next;

    logic            v1_reg, v2_reg, v3_reg;
    logic [XW-1:0]   dx_reg, dy_reg;
    logic [SQW-1:0]  sqx_reg, sqy_reg, rr2_reg;
    logic [D2_W-1:0] d2q_reg;
    side_t           side1_reg, side2_reg, side3_reg;

    assign pcx = XW'({pixel_x, 1'b1}) << FRAC_BITS;
    assign pcy = XW'({pixel_y, 1'b1}) << FRAC_BITS;
    assign ccx = {center_x, 1'b0};
    assign ccy = {center_y, 1'b0};
    assign rr  = {glow_radius, 1'b0};

    assign dx_next = (pcx >= ccx) ? pcx - ccx : ccx - pcx;
    assign dy_next = (pcy >= ccy) ? pcy - ccy : ccy - pcy;

    assign d2 = SUMW'(sqx_reg) + SUMW'(sqy_reg);

    generate
        if (FRAC_BITS <= 7) begin : g_up
            assign d2q_next = D2_W'(d2) << (14 - 2*FRAC_BITS);
        end else begin : g_down
            assign d2q_next = D2_W'(d2 >> (2*FRAC_BITS - 14));
        end
    endgenerate

    always_comb
    begin
        side3_next         = side2_reg;
        side3_next.in_glow = (d2 < SUMW'(rr2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            side1_reg <= in_side;
            sqx_reg   <= SQW'(dx_reg) * SQW'(dx_reg);
            sqy_reg   <= SQW'(dy_reg) * SQW'(dy_reg);
            rr2_reg   <= SQW'(rr) * SQW'(rr);
            side2_reg <= side1_reg;
            d2q_reg   <= d2q_next;
            side3_reg <= side3_next;
        end
    end

    assign out_valid = v3_reg;
    assign d2q       = d2q_reg;
    assign out_side  = side3_reg;

endmodule

`default_nettype wire

// ===== rtl/rgb_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module rgb_sqrt
    import rgb_pkg::*;
#(
    parameter int IN_W = 42
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [IN_W-1:0]   radicand,
    input  wire side_t             in_side,
    output logic                   out_valid,
    output logic [IN_W/2-1:0]      root,
    output side_t                  out_side
);

    localparam int RW = IN_W / 2;

    logic            v_reg    [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [IN_W-1:0] rad_reg  [RW];
    side_t           side_reg [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic            v_in;
            logic [RW+1:0]   rem_in;
            logic [RW-1:0]   root_in;
            logic [IN_W-1:0] rad_in;
            side_t           side_in;
            logic [RW+1:0]   rem_sh;
            logic [RW+1:0]   trial;
            logic            ge;

            if (k == 0) begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = radicand;
                assign side_in = in_side;
            end else begin : g_next
                assign v_in    = v_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rad_in  = rad_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            assign rem_sh = {rem_in[RW-1:0], rad_in[IN_W-1 -: 2]};
            assign trial  = {root_in, 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                    root_reg[k] <= {root_in[RW-2:0], ge};
                    rad_reg[k]  <= rad_in << 2;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

`default_nettype wire

// ===== rtl/rgb_div.sv =====
// Pipelined restoring divider: Q0.16 ratio of distance to radius.
`default_nettype none

module rgb_div
    import rgb_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4,
    parameter int DIST_W     = COORD_BITS + 9
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [DIST_W-1:0]               dist_val,
    input  wire side_t                           in_side,
    input  wire logic [COORD_BITS+FRAC_BITS-1:0] glow_radius,
    output logic                                 out_valid,
    output logic [RATIO_W-1:0]                   ratio,
    output side_t                                out_side
);

    localparam int P  = COORD_BITS + FRAC_BITS;
    localparam int NW = DIST_W + 8 + FRAC_BITS;

    logic [NW-1:0] num;

    logic               v_reg    [RATIO_W];
    logic [P-1:0]       rem_reg  [RATIO_W];
    logic [RATIO_W-1:0] lo_reg   [RATIO_W];
    logic [RATIO_W-1:0] q_reg    [RATIO_W];
    side_t              side_reg [RATIO_W];

    assign num = NW'(dist_val) << (8 + FRAC_BITS);

    genvar k;
    generate
        for (k = 0; k < RATIO_W; k++) begin : g_stage
            logic               v_in;
            logic [P-1:0]       rem_in;
            logic [RATIO_W-1:0] lo_in;
            logic [RATIO_W-1:0] q_in;
            side_t              side_in;
            logic [P:0]         rem_sh;
            logic               ge;

            if (k == 0) begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = num[RATIO_W +: P];
                assign lo_in   = num[RATIO_W-1:0];
                assign q_in    = '0;
                assign side_in = in_side;
            end else begin : g_next
                assign v_in    = v_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign lo_in   = lo_reg[k-1];
                assign q_in    = q_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            assign rem_sh = {rem_in, lo_in[RATIO_W-1]};
            assign ge     = (rem_sh >= {1'b0, glow_radius});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? P'(rem_sh - {1'b0, glow_radius}) : rem_sh[P-1:0];
                    lo_reg[k]   <= lo_in << 1;
                    q_reg[k]    <= {q_in[RATIO_W-2:0], ge};
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[RATIO_W-1];
    assign ratio     = q_reg[RATIO_W-1];
    assign out_side  = side_reg[RATIO_W-1];

endmodule

`default_nettype wire

// ===== rtl/rgb_blend.sv =====
// Glow opacity from the ratio and source-over blend of the four channels.
`default_nettype none

module rgb_blend
    import rgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [RATIO_W-1:0] ratio,
    input  wire side_t              in_side,
    input  wire logic [CHAN_W-1:0]  glow_red,
    input  wire logic [CHAN_W-1:0]  glow_green,
    input  wire logic [CHAN_W-1:0]  glow_blue,
    input  wire logic [CHAN_W-1:0]  glow_alpha,
    output logic                    out_valid,
    output logic [CHAN_W-1:0]       out_red,
    output logic [CHAN_W-1:0]       out_green,
    output logic [CHAN_W-1:0]       out_blue,
    output logic [CHAN_W-1:0]       out_alpha,
    output logic                    inside_glow
);

    localparam int NCH = 4;

    logic [RATIO_W-1:0] t_next;
    logic [39:0]        ga_prod;
    logic [CHAN_W-1:0]  src [NCH];
    logic [CHAN_W-1:0]  dst [NCH];
    logic [CHAN_W-1:0]  dst5 [NCH];
    logic [CHAN_W-1:0]  res [NCH];

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [31:0]       tt_reg;
    logic [CHAN_W-1:0] ga_reg;
    logic [15:0]       num_reg [NCH];
    logic [16:0]       x_reg   [NCH];
    logic [CHAN_W-1:0] q0_reg  [NCH];
    logic [CHAN_W-1:0] res_reg [NCH];
    side_t             side1_reg, side2_reg, side3_reg, side4_reg;
    logic              inside_reg;

    assign t_next  = (ratio == '0) ? '1 : RATIO_W'(17'h10000 - 17'(ratio));
    assign ga_prod = 40'(tt_reg) * 40'(glow_alpha) + 40'h0080000000;

    assign src[0] = glow_red;
    assign src[1] = glow_green;
    assign src[2] = glow_blue;
    assign src[3] = 8'hFF;
    assign dst[0] = side2_reg.red;
    assign dst[1] = side2_reg.green;
    assign dst[2] = side2_reg.blue;
    assign dst[3] = side2_reg.alpha;
    assign dst5[0] = side4_reg.red;
    assign dst5[1] = side4_reg.green;
    assign dst5[2] = side4_reg.blue;
    assign dst5[3] = side4_reg.alpha;

    always_comb
    begin
        logic [16:0] rem;
        for (int c = 0; c < NCH; c++)
        begin
            rem = x_reg[c] - 17'(q0_reg[c]) * 17'd510;
            if (!side4_reg.in_glow)
                res[c] = dst5[c];
            else if (rem >= 17'd510)
                res[c] = q0_reg[c] + 8'd1;
            else
                res[c] = q0_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg    <= 32'(t_next) * 32'(t_next);
            side1_reg <= in_side;
            ga_reg    <= ga_prod[39:32];
            side2_reg <= side1_reg;
            for (int c = 0; c < NCH; c++)
            begin
                num_reg[c] <= 16'(src[c]) * 16'(ga_reg)
                            + 16'(dst[c]) * 16'(8'hFF - ga_reg);
                x_reg[c]   <= {num_reg[c], 1'b0} + 17'd255;
                q0_reg[c]  <= CHAN_W'((32'({num_reg[c], 1'b0} + 17'd255) * 32'd16448) >> 23);
                res_reg[c] <= res[c];
            end
            side3_reg  <= side2_reg;
            side4_reg  <= side3_reg;
            inside_reg <= side4_reg.in_glow;
        end
    end

    assign out_valid   = v5_reg;
    assign out_red     = res_reg[0];
    assign out_green   = res_reg[1];
    assign out_blue    = res_reg[2];
    assign out_alpha   = res_reg[3];
    assign inside_glow = inside_reg;

endmodule

`default_nettype wire

// ===== rtl/radial_glow_blend.sv =====
// Top level of the radial glow blender: config registers and the pixel pipeline.
`default_nettype none

// Blends a radial glow into a stream of RGBA pixels, one pixel word per clock
// while the output is not stalled. The pipeline has three distance stages, one
// square-root stage per distance bit (COORD_BITS + 9), one divider stage per ratio
// bit and five blend stages. All stages advance together; when a finished word is
// held at the output the whole pipeline holds and the input is not ready. Config
// writes belong in idle periods only.
module radial_glow_blend
    import rgb_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [COORD_BITS+FRAC_BITS-1:0] cfg_wdata,
    pix_in_if.sink                               pix_in,
    pix_out_if.source                            pix_out
);

    localparam int POS_W  = COORD_BITS + FRAC_BITS;
    localparam int D2_W   = 2*COORD_BITS + 18;
    localparam int DIST_W = D2_W / 2;

    logic [POS_W-1:0]  center_x_reg, center_y_reg, glow_radius_reg;
    logic [CHAN_W-1:0] glow_red_reg, glow_green_reg, glow_blue_reg, glow_alpha_reg;

    logic               en;
    side_t              in_side;
    logic               d_valid, s_valid, q_valid;
    logic [D2_W-1:0]    d2q;
    logic [DIST_W-1:0]  dist_val;
    logic [RATIO_W-1:0] ratio;
    side_t              d_side, s_side, q_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            glow_radius_reg <= POS_W'(16);
            glow_red_reg    <= '0;
            glow_green_reg  <= '0;
            glow_blue_reg   <= '0;
            glow_alpha_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_CENTER_X:    center_x_reg    <= cfg_wdata;
                CFG_CENTER_Y:    center_y_reg    <= cfg_wdata;
                CFG_GLOW_RADIUS: glow_radius_reg <= cfg_wdata;
                CFG_GLOW_RED:    glow_red_reg    <= cfg_wdata[CHAN_W-1:0];
                CFG_GLOW_GREEN:  glow_green_reg  <= cfg_wdata[CHAN_W-1:0];
                CFG_GLOW_BLUE:   glow_blue_reg   <= cfg_wdata[CHAN_W-1:0];
                CFG_GLOW_ALPHA:  glow_alpha_reg  <= cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign en           = !pix_out.valid || pix_out.ready;
    assign pix_in.ready = en;

    assign in_side.red     = pix_in.dst_red;
    assign in_side.green   = pix_in.dst_green;
    assign in_side.blue    = pix_in.dst_blue;
    assign in_side.alpha   = pix_in.dst_alpha;
    assign in_side.in_glow = 1'b0;

    rgb_dist #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .D2_W       (D2_W)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (pix_in.valid),
        .pixel_x     (pix_in.pixel_x),
        .pixel_y     (pix_in.pixel_y),
        .in_side     (in_side),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .glow_radius (glow_radius_reg),
        .out_valid   (d_valid),
        .d2q         (d2q),
        .out_side    (d_side)
    );

    rgb_sqrt #(
        .IN_W (D2_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .radicand  (d2q),
        .in_side   (d_side),
        .out_valid (s_valid),
        .root      (dist_val),
        .out_side  (s_side)
    );

    rgb_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .DIST_W     (DIST_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_valid),
        .dist_val    (dist_val),
        .in_side     (s_side),
        .glow_radius (glow_radius_reg),
        .out_valid   (q_valid),
        .ratio       (ratio),
        .out_side    (q_side)
    );

    rgb_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (q_valid),
        .ratio       (ratio),
        .in_side     (q_side),
        .glow_red    (glow_red_reg),
        .glow_green  (glow_green_reg),
        .glow_blue   (glow_blue_reg),
        .glow_alpha  (glow_alpha_reg),
        .out_valid   (pix_out.valid),
        .out_red     (pix_out.out_red),
        .out_green   (pix_out.out_green),
        .out_blue    (pix_out.out_blue),
        .out_alpha   (pix_out.out_alpha),
        .inside_glow (pix_out.inside_glow)
    );

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && !pix_out.ready) |-> !pix_in.ready)
        else $error("input accepted while output is stalled");

    a_zero_radius_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && glow_radius_reg == '0) |-> !pix_out.inside_glow)
        else $error("pixel inside a zero radius glow");
`endif

endmodule

`default_nettype wire
